// ===== sv/tdpsc_pkg.sv =====
// Shared types, constants and register indexes of the tank drive speed controller.
// No dependencies.
`default_nettype none
package tdpsc_pkg;
  localparam int unsigned PwmFullScale = 2550;
  localparam int unsigned IntegWidth = 48;
  localparam int unsigned Unity = 65536;

  typedef enum logic [2:0] {
    REG_GAIN_PROP      = 3'd0,
    REG_GAIN_INTEG     = 3'd1,
    REG_GAIN_DERIV     = 3'd2,
    REG_STEER_DEADZONE = 3'd3,
    REG_TOP_SPEED_RPM  = 3'd4,
    REG_STEPS_PER_TURN = 3'd5
  } reg_idx_e;

  // request and answer of the shared bit-serial divider
  typedef struct packed {
    logic        start;
    logic [95:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] quotient;
    logic [63:0] remainder;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== sv/tank_drive_pid_speed_controller.sv =====
// Top level of the tank drive PID speed controller: sequencer, state and registers.
// Depends on tdpsc_pkg, tdpsc_divider and tdpsc_multiplier.
//
// Usage: one input transaction is one control tick carrying triggers, stick,
// four encoder counts, elapsed microseconds and the link-lost flag. The block
// answers with one output transaction of eight PWM levels.
// Operation: a tick runs as a sequence of multiplies and divides on one
// shared shift-add multiplier and one shared bit-serial divider; with
// link_lost set the sequence is skipped and the result is valid in the
// cycle after acceptance. One tick is worked on at a time; in_stall_o is
// high from acceptance until the result is taken, so a new tick can be
// accepted in the cycle after the result leaves.
// Reset: gains and limits take their default values, encoder history,
// integrators and previous errors clear to zero.
// A stalled result holds on the output ports until out_stall_i falls.
// Configuration writes are taken any time cfg_ready_o is high (always).
`default_nettype none
module tank_drive_pid_speed_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  fwd_trigger_i,
  input  wire logic [7:0]  rev_trigger_i,
  input  wire logic [7:0]  stick_x_i,
  input  wire logic signed [31:0] count_front_left_i,
  input  wire logic signed [31:0] count_front_right_i,
  input  wire logic signed [31:0] count_rear_left_i,
  input  wire logic signed [31:0] count_rear_right_i,
  input  wire logic [23:0] elapsed_us_i,
  input  wire logic        link_lost_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      fl_forward_level_o,
  output logic [11:0]      fl_reverse_level_o,
  output logic [11:0]      fr_forward_level_o,
  output logic [11:0]      fr_reverse_level_o,
  output logic [11:0]      rl_forward_level_o,
  output logic [11:0]      rl_reverse_level_o,
  output logic [11:0]      rr_forward_level_o,
  output logic [11:0]      rr_reverse_level_o
);
  import tdpsc_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_THR    = 16'h0002,
    S_STEER  = 16'h0004,
    S_DZ     = 16'h0008,
    S_MIX    = 16'h0010,
    S_WHEEL  = 16'h0020,
    S_SPDMUL = 16'h0040,
    S_SPDDIV = 16'h0080,
    S_SPDFR  = 16'h0100,
    S_ERR    = 16'h0200,
    S_PMUL   = 16'h0400,
    S_IMUL   = 16'h0800,
    S_DMUL   = 16'h1000,
    S_DDIV   = 16'h2000,
    S_LEVEL  = 16'h4000,
    S_OUT    = 16'h8000
  } state_e;

  localparam logic signed [63:0] TermLim = 64'sd1 << 40;
  localparam logic signed [63:0] IMax = (64'sd1 <<< (IntegWidth - 1)) - 64'sd1;
  localparam logic signed [63:0] IMin = -IMax - 64'sd1;
  localparam logic signed [63:0] UnityS = 64'(Unity);

  state_e state_q;
  logic signed [31:0] gp_q, gi_q, gd_q;
  logic [15:0] dz_q, rpm_q, spt_q;
  logic [31:0] prev_cnt_q [4];
  logic signed [63:0] integ_q [4];
  logic signed [31:0] prev_err_q [4];

  logic [7:0]  fwd_q, rev_q, stick_q;
  logic [31:0] cnt_in_q [4];
  logic [23:0] el_q;
  logic [1:0]  w_q;
  logic [1:0]  sub_q;
  logic        mix_side_q;
  logic signed [63:0] thr_q, st_q, left_q, right_q;
  logic signed [31:0] delta_q, err_q;
  logic signed [63:0] speed_q, pterm_q, iterm_q, dterm_q, diff_q;
  logic [63:0] tmp_q;
  logic        neg_q;
  logic [11:0] lvl_q [8];
  logic        wait_q;

  div_req_t dreq;
  div_rsp_t drsp;
  logic        mstart;
  logic [63:0] ma;
  logic [31:0] mb;
  logic        mdone;
  logic [95:0] mprod;

  tdpsc_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  tdpsc_multiplier u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
    .done_o(mdone), .prod_o(mprod)
  );

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sgn(input logic [63:0] m, input logic n);
    return n ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               input logic signed [63:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // values used by the current wheel
  logic [31:0] cnt_now;
  logic signed [63:0] tgt_now, err_full, s_old, s_new, sum3, drive;
  logic [63:0] mprod_lo;
  always_comb begin
    cnt_now  = (w_q < 2'd2) ? 32'(-cnt_in_q[w_q]) : cnt_in_q[w_q];
    tgt_now  = w_q[0] ? right_q : left_q;
    err_full = tgt_now - speed_q;
    if (err_full > 64'sd2147483647) err_full = 64'sd2147483647;
    else if (err_full < -64'sd2147483648) err_full = -64'sd2147483648;
    s_old = integ_q[w_q];
    s_new = s_old + err_full;
    if (s_new > IMax) s_new = IMax;
    else if (s_new < IMin) s_new = IMin;
    mprod_lo = (mprod[95:64] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : mprod[63:0];
    sum3  = pterm_q + iterm_q + dterm_q;
    drive = clamp(sum3, UnityS);
  end

  // scale a Q16 product magnitude down, saturate it to the term limit and apply the sign
  function automatic logic signed [63:0] q16term(input logic [63:0] p, input logic n);
    logic [63:0] m;
    m = p >> 16;
    if (m > 64'(TermLim)) m = 64'(TermLim);
    return sgn(m, n);
  endfunction

  // mix value for the side in work
  logic signed [63:0] mixv;
  always_comb begin
    mixv = sub_q[0] ? clamp(thr_q - st_q, UnityS) : clamp(thr_q + st_q, UnityS);
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q  <= 32'sd67109;
      gi_q  <= '0;
      gd_q  <= '0;
      dz_q  <= 16'd6554;
      rpm_q <= 16'd1200;
      spt_q <= 16'd200;
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
      w_q     <= '0;
      sub_q   <= '0;
      mix_side_q <= 1'b0;
      thr_q   <= '0;
      st_q    <= '0;
      left_q  <= '0;
      right_q <= '0;
      delta_q <= '0;
      err_q   <= '0;
      speed_q <= '0;
      pterm_q <= '0;
      iterm_q <= '0;
      dterm_q <= '0;
      diff_q  <= '0;
      tmp_q   <= '0;
      for (int k = 0; k < 8; k++) lvl_q[k] <= '0;
      for (int i = 0; i < 4; i++) begin
        prev_cnt_q[i] <= '0;
        integ_q[i]    <= '0;
        prev_err_q[i] <= '0;
      end
    end else begin
      // register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_GAIN_PROP:      gp_q  <= cfg_data_i;
          REG_GAIN_INTEG:     gi_q  <= cfg_data_i;
          REG_GAIN_DERIV:     gd_q  <= cfg_data_i;
          REG_STEER_DEADZONE: dz_q  <= cfg_data_i[15:0];
          REG_TOP_SPEED_RPM:  rpm_q <= cfg_data_i[15:0];
          REG_STEPS_PER_TURN: spt_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            for (int k = 0; k < 8; k++) lvl_q[k] <= '0;
            state_q <= link_lost_i ? S_OUT : S_THR;
            wait_q  <= 1'b0;
          end
        end
        // throttle = (fwd-rev)*65536/255
        S_THR: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (drsp.done) begin
            thr_q   <= sgn(drsp.quotient[63:0], fwd_q < rev_q);
            wait_q  <= 1'b0;
            state_q <= S_STEER;
          end
        end
        S_STEER: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (drsp.done) begin
            st_q    <= sgn(drsp.quotient[63:0], stick_q < 8'd128);
            wait_q  <= 1'b0;
            state_q <= S_DZ;
          end
        end
        // deadzone rescale
        S_DZ: begin
          if (!wait_q) begin
            if (mag(st_q) <= 64'(dz_q)) begin
              st_q <= '0;
              state_q <= S_MIX;
              sub_q <= '0;
            end else wait_q <= 1'b1;
          end else if (drsp.done) begin
            st_q    <= sgn(drsp.quotient[63:0], st_q[63]);
            wait_q  <= 1'b0;
            state_q <= S_MIX;
            sub_q   <= '0;
          end
        end
        // target = clamp(mix)*rpm/256, left then right
        S_MIX: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
            mix_side_q <= sub_q[0];
          end else if (mdone) begin
            if (!mix_side_q) left_q <= sgn(mprod[63:0] >> 8, neg_q);
            else right_q <= sgn(mprod[63:0] >> 8, neg_q);
            wait_q <= 1'b0;
            if (sub_q[0]) begin
              state_q <= S_WHEEL;
              w_q <= '0;
            end else sub_q <= 2'd1;
          end
        end
        S_WHEEL: begin
          delta_q <= cnt_now - prev_cnt_q[w_q];
          prev_cnt_q[w_q] <= cnt_now;
          speed_q <= '0;
          state_q <= (el_q == 24'd0 || spt_q == 16'd0) ? S_ERR : S_SPDMUL;
        end
        // |delta| * 60e6
        S_SPDMUL: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (mdone) begin
            tmp_q   <= mprod[63:0];
            wait_q  <= 1'b0;
            state_q <= S_SPDDIV;
          end
        end
        S_SPDDIV: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (drsp.done) begin
            wait_q <= 1'b0;
            if (drsp.quotient[63:23] != '0) begin
              speed_q <= sgn(64'h7FFF_FFFF, delta_q[31]);
              state_q <= S_ERR;
            end else begin
              speed_q <= 64'(drsp.quotient[22:0]) << 8;
              tmp_q   <= drsp.remainder << 8;
              state_q <= S_SPDFR;
            end
          end
        end
        S_SPDFR: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (drsp.done) begin
            wait_q <= 1'b0;
            if ((speed_q + $signed(drsp.quotient[63:0])) > 64'sh7FFF_FFFF)
              speed_q <= sgn(64'h7FFF_FFFF, delta_q[31]);
            else speed_q <= sgn(64'(speed_q) + drsp.quotient[63:0], delta_q[31]);
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          err_q <= err_full[31:0];
          integ_q[w_q] <= s_new;
          diff_q <= err_full - 64'(prev_err_q[w_q]);
          prev_err_q[w_q] <= err_full[31:0];
          state_q <= S_PMUL;
        end
        S_PMUL: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (mdone) begin
            pterm_q <= q16term(mprod_lo, gp_q[31] != err_q[31]);
            wait_q  <= 1'b0;
            state_q <= S_IMUL;
          end
        end
        S_IMUL: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (mdone) begin
            iterm_q <= q16term(mprod_lo, gi_q[31] != integ_q[w_q][63]);
            wait_q  <= 1'b0;
            dterm_q <= '0;
            state_q <= (el_q == 24'd0) ? S_LEVEL : S_DMUL;
          end
        end
        S_DMUL: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (mdone) begin
            tmp_q   <= mprod[63:0];
            wait_q  <= 1'b0;
            state_q <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (!wait_q) wait_q <= 1'b1;
          else if (drsp.done) begin
            dterm_q <= q16term(drsp.quotient[63:0], gd_q[31] != diff_q[63]);
            wait_q  <= 1'b0;
            state_q <= S_LEVEL;
          end
        end
        // split |drive|*2550/65536 into forward or reverse
        S_LEVEL: begin
          if (!drive[63]) lvl_q[{w_q, 1'b0}] <=
            12'((64'(drive) * 64'(PwmFullScale)) >> 16);
          else lvl_q[{w_q, 1'b1}] <= 12'((mag(drive) * 64'(PwmFullScale)) >> 16);
          if (w_q == 2'd3) state_q <= S_OUT;
          else begin
            w_q <= w_q + 2'd1;
            state_q <= S_WHEEL;
          end
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // capture the tick
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      fwd_q   <= fwd_trigger_i;
      rev_q   <= rev_trigger_i;
      stick_q <= stick_x_i;
      cnt_in_q[0] <= count_front_left_i;
      cnt_in_q[1] <= count_front_right_i;
      cnt_in_q[2] <= count_rear_left_i;
      cnt_in_q[3] <= count_rear_right_i;
      el_q <= elapsed_us_i;
    end
    if (state_q == S_MIX && !wait_q) neg_q <= mixv[63];
  end

  // start and operands of the shared units
  always_comb begin
    dreq = '0;
    mstart = 1'b0;
    ma = '0;
    mb = '0;
    if (!wait_q) begin
      case (state_q)
        S_THR: begin
          dreq.start = 1'b1;
          dreq.dividend = 96'((fwd_q > rev_q ? fwd_q - rev_q : rev_q - fwd_q)) << 16;
          dreq.divisor = 64'd255;
        end
        S_STEER: begin
          dreq.start = 1'b1;
          dreq.dividend = 96'(stick_q < 8'd128 ? 9'd255 - {stick_q, 1'b0}
                                               : {stick_q, 1'b0} - 9'd255) << 16;
          dreq.divisor = 64'd255;
        end
        S_DZ: begin
          dreq.start = (mag(st_q) > 64'(dz_q));
          dreq.dividend = 96'(mag(st_q) - 64'(dz_q)) << 16;
          dreq.divisor = 64'(Unity) - 64'(dz_q);
        end
        S_MIX: begin
          mstart = 1'b1;
          ma = mag(mixv);
          mb = 32'(rpm_q);
        end
        S_SPDMUL: begin
          mstart = 1'b1;
          ma = mag(64'(delta_q));
          mb = 32'd60000000;
        end
        S_SPDDIV, S_SPDFR: begin
          dreq.start = 1'b1;
          dreq.dividend = 96'(tmp_q);
          dreq.divisor = 64'(spt_q) * 64'(el_q);
        end
        S_PMUL: begin
          mstart = 1'b1;
          ma = 64'(mag(64'(err_q)));
          mb = 32'(mag(64'(gp_q)));
        end
        S_IMUL: begin
          mstart = 1'b1;
          ma = mag(integ_q[w_q]);
          mb = 32'(mag(64'(gi_q)));
        end
        S_DMUL: begin
          mstart = 1'b1;
          ma = mag(diff_q);
          mb = 32'(mag(64'(gd_q)));
        end
        // divide by the elapsed time; the Q16 shift follows in q16term
        S_DDIV: begin
          dreq.start = 1'b1;
          dreq.dividend = 96'(tmp_q);
          dreq.divisor = 64'(el_q);
        end
        default: ;
      endcase
    end
  end

  assign fl_forward_level_o = lvl_q[0];
  assign fl_reverse_level_o = lvl_q[1];
  assign fr_forward_level_o = lvl_q[2];
  assign fr_reverse_level_o = lvl_q[3];
  assign rl_forward_level_o = lvl_q[4];
  assign rl_reverse_level_o = lvl_q[5];
  assign rr_forward_level_o = lvl_q[6];
  assign rr_reverse_level_o = lvl_q[7];
endmodule
`default_nettype wire

// ===== sv/tdpsc_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tdpsc_pkg.
`default_nettype none
module tdpsc_divider (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tdpsc_pkg::div_req_t req_i,
  output tdpsc_pkg::div_rsp_t      rsp_o
);
  import tdpsc_pkg::*;

  logic [95:0] quo_q;
  logic [64:0] rem_q;
  logic [63:0] dsr_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] trial;
  logic [64:0] shifted;

  // shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    shifted = {rem_q[63:0], quo_q[95]};
    trial   = shifted - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd96;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial;
        quo_q <= {quo_q[94:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[94:0], 1'b0};
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[63:0];
endmodule
`default_nettype wire

// ===== sv/tdpsc_multiplier.sv =====
// Shift-and-add multiplier, 64 by 32 bits unsigned, one multiplier bit a cycle.
// Depends on tdpsc_pkg.
`default_nettype none
module tdpsc_multiplier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [95:0]      prod_o
);
  import tdpsc_pkg::*;

  logic [95:0] acc_q, mcand_q;
  logic [31:0] mplier_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // add the shifted multiplicand where the low multiplier bit is set
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= {32'd0, a_i};
      mplier_q <= b_i;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= {mcand_q[94:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[31:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
`default_nettype wire
